### hw/rtl/lio_pkg.sv
package lio_pkg;

    // Fixed field widths
    localparam int CFG_W    = 7;
    localparam int OUT_W    = 13;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Neighbour walk order during scoring
    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_DOWN  = 3'd3;
    localparam logic [2:0] DIR_DONE  = 3'd4;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_UP_CHK   = 16'h0002,
        ST_LEFT_CHK = 16'h0004,
        ST_FIND_RD  = 16'h0008,
        ST_FIND_CHK = 16'h0010,
        ST_AR_A     = 16'h0020,
        ST_AR_B     = 16'h0040,
        ST_LINK     = 16'h0080,
        ST_FINISH   = 16'h0100,
        ST_SC_RD    = 16'h0200,
        ST_SC_CHK   = 16'h0400,
        ST_NB_SEL   = 16'h0800,
        ST_NB_CHK   = 16'h1000,
        ST_NB_AREA  = 16'h2000,
        ST_SC_NEXT  = 16'h4000,
        ST_OUT      = 16'h8000
    } state_t;

    // Who asked for the current root search
    typedef enum logic [1:0] {
        ROLE_A  = 2'd0,
        ROLE_B  = 2'd1,
        ROLE_SC = 2'd2
    } role_t;

endpackage

### hw/rtl/lio_ram.sv
module lio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/largest_island_after_one_flip_unit.sv
// Channel  | Dir | Ports                      | Payload
// ---------+-----+----------------------------+---------------------------------
// s        | in  | s_tvalid s_tready s_tdata  | [0] cell_value, [7:1] ignored
// m        | out | m_tvalid m_tready m_tdata  | [12:0] largest_island, [15:13] 0
// cfg      | in  | cfg_wen cfg_data           | grid_side, taken while idle
//
// Per cell: a water cell goes from idle straight to finish; a land cell also
//   passes the up check (not on the top row) and the left check, plus, for
//   each land neighbour above or to the left, two root searches that read one
//   node at a time (the root included) over the link memory's single read port
//   and, when the roots differ, a join of the two trees. Union by size keeps
//   trees at most log2(side*side) deep. After the last cell a scoring sweep reads
//   every cell: a water cell checks each neighbour inside the grid and, per land
//   neighbour, runs a root search and reads the area of each new root.
// Reset: no clearing pass. Each cell's link and area entries are set when
//   the cell arrives, and only cells already received are ever visited.
// Stalls: input is taken only when idle and no register write is present;
//   the result waits in an output register, and a second grid's result waits
//   until it is taken.
module largest_island_after_one_flip_unit
    import lio_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_data,   // grid_side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // [0] cell_value
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata     // [12:0] largest_island
);

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int AW     = $clog2(CELLS);
    localparam int AREA_W = AW + 1;
    localparam int RW     = $clog2(MAX_SIDE);

    state_t             state_reg, state_next;
    role_t              role_reg, role_next;
    logic [CFG_W-1:0]   side_cfg_reg, side_cfg_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      col_reg, col_next;
    logic               cur_bit_reg, cur_bit_next;
    logic               prev_bit_reg, prev_bit_next;
    logic               mleft_reg, mleft_next;
    logic [AREA_W-1:0]  best_reg, best_next;
    logic [AREA_W-1:0]  sbest_reg, sbest_next;
    logic [AREA_W-1:0]  total_reg, total_next;
    logic [AREA_W-1:0]  area_a_reg, area_a_next;
    logic [AW-1:0]      x_reg, x_next;
    logic [AW-1:0]      nb_reg, nb_next;
    logic [AW-1:0]      ra_reg, ra_next;
    logic [2:0]         dir_reg, dir_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [AW-1:0]      roots_reg [4];
    logic [AW-1:0]      roots_next [4];
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // Memory ports
    logic               cell_we, cell_q;
    logic [AW-1:0]      cell_raddr;
    logic               link_we;
    logic [AW-1:0]      link_waddr, link_wdata, link_q;
    logic               area_we;
    logic [AW-1:0]      area_waddr, area_raddr;
    logic [AREA_W-1:0]  area_wdata, area_q;

    // Active side, clamped to 1..MAX_SIDE
    logic [31:0]        side32;
    logic [AW-1:0]      side_a;
    logic [RW-1:0]      side_lm1;
    logic               last_cell;
    logic [AREA_W-1:0]  sum;
    logic               dup;
    logic               nb_ok;
    logic [AW-1:0]      nb_addr;

    always_comb
    begin
        if (side_cfg_reg == '0)
        begin
            side32 = 32'd1;
        end
        else if (32'(side_cfg_reg) > MAX_SIDE)
        begin
            side32 = MAX_SIDE;
        end
        else
        begin
            side32 = 32'(side_cfg_reg);
        end
    end

    assign side_a    = AW'(side32);
    assign side_lm1  = RW'(side32 - 32'd1);
    assign last_cell = (row_reg == side_lm1) && (col_reg == side_lm1);
    assign sum       = area_a_reg + area_q;

    always_comb
    begin
        dup = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if ((3'(i) < cnt_reg) && (roots_reg[i] == x_reg))
            begin
                dup = 1'b1;
            end
        end
    end

    // Neighbour of the scored cell in the current direction
    always_comb
    begin
        nb_ok   = 1'b0;
        nb_addr = k_reg;
        case (dir_reg)
            DIR_UP:
            begin
                nb_ok   = (row_reg != '0);
                nb_addr = k_reg - side_a;
            end
            DIR_LEFT:
            begin
                nb_ok   = (col_reg != '0);
                nb_addr = k_reg - AW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok   = (col_reg != side_lm1);
                nb_addr = k_reg + AW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok   = (row_reg != side_lm1);
                nb_addr = k_reg + side_a;
            end
            default:
            begin
                nb_ok   = 1'b0;
                nb_addr = k_reg;
            end
        endcase
    end

    // A register write takes the idle cycle, so no item is taken beside it
    assign s_tready = (state_reg == ST_IDLE) && !cfg_wen;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

    always_comb
    begin
        state_next    = state_reg;
        role_next     = role_reg;
        side_cfg_next = side_cfg_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cur_bit_next  = cur_bit_reg;
        prev_bit_next = prev_bit_reg;
        mleft_next    = mleft_reg;
        best_next     = best_reg;
        sbest_next    = sbest_reg;
        total_next    = total_reg;
        area_a_next   = area_a_reg;
        x_next        = x_reg;
        nb_next       = nb_reg;
        ra_next       = ra_reg;
        dir_next      = dir_reg;
        cnt_next      = cnt_reg;
        roots_next    = roots_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;

        cell_we    = 1'b0;
        cell_raddr = k_reg;
        link_we    = 1'b0;
        link_waddr = k_reg;
        link_wdata = k_reg;
        area_we    = 1'b0;
        area_waddr = k_reg;
        area_wdata = AREA_W'(1);
        area_raddr = x_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wen)
                begin
                    side_cfg_next = cfg_data;
                    k_next        = '0;
                    row_next      = '0;
                    col_next      = '0;
                end
                else if (s_tvalid)
                begin
                    // Fresh singleton set for this cell
                    cell_we      = 1'b1;
                    link_we      = 1'b1;
                    area_we      = 1'b1;
                    cell_raddr   = k_reg - side_a;
                    cur_bit_next = s_tdata[0];
                    if (k_reg == '0)
                    begin
                        best_next = AREA_W'(s_tdata[0]);
                    end
                    else if (s_tdata[0] && (best_reg == '0))
                    begin
                        best_next = AREA_W'(1);
                    end
                    if (!s_tdata[0])
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (row_reg != '0)
                    begin
                        state_next = ST_UP_CHK;
                    end
                    else
                    begin
                        state_next = ST_LEFT_CHK;
                    end
                end
            end
            ST_UP_CHK:
            begin
                if (cell_q)
                begin
                    x_next     = k_reg;
                    nb_next    = k_reg - side_a;
                    role_next  = ROLE_A;
                    mleft_next = 1'b0;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    state_next = ST_LEFT_CHK;
                end
            end
            ST_LEFT_CHK:
            begin
                if ((col_reg != '0) && prev_bit_reg)
                begin
                    x_next     = k_reg;
                    nb_next    = k_reg - AW'(1);
                    role_next  = ROLE_A;
                    mleft_next = 1'b1;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CHK;
            end
            ST_FIND_CHK:
            begin
                if (link_q != x_reg)
                begin
                    x_next     = link_q;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    case (role_reg)
                        ROLE_A:
                        begin
                            ra_next    = x_reg;
                            x_next     = nb_reg;
                            role_next  = ROLE_B;
                            state_next = ST_FIND_RD;
                        end
                        ROLE_B:
                        begin
                            if (x_reg == ra_reg)
                            begin
                                state_next = mleft_reg ? ST_FINISH : ST_LEFT_CHK;
                            end
                            else
                            begin
                                state_next = ST_AR_A;
                            end
                        end
                        ROLE_SC:
                        begin
                            if (dup)
                            begin
                                dir_next   = dir_reg + 3'd1;
                                state_next = ST_NB_SEL;
                            end
                            else
                            begin
                                // area read of this root issued now
                                roots_next[cnt_reg[1:0]] = x_reg;
                                cnt_next   = cnt_reg + 3'd1;
                                state_next = ST_NB_AREA;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_AR_A:
            begin
                area_raddr = ra_reg;
                state_next = ST_AR_B;
            end
            ST_AR_B:
            begin
                area_a_next = area_q;
                state_next  = ST_LINK;
            end
            ST_LINK:
            begin
                // Smaller tree hangs below the larger one
                link_we = 1'b1;
                area_we = 1'b1;
                area_wdata = sum;
                if (area_a_reg < area_q)
                begin
                    link_waddr = ra_reg;
                    link_wdata = x_reg;
                    area_waddr = x_reg;
                end
                else
                begin
                    link_waddr = x_reg;
                    link_wdata = ra_reg;
                    area_waddr = ra_reg;
                end
                if (sum > best_reg)
                begin
                    best_next = sum;
                end
                state_next = mleft_reg ? ST_FINISH : ST_LEFT_CHK;
            end
            ST_FINISH:
            begin
                prev_bit_next = cur_bit_reg;
                if (last_cell)
                begin
                    k_next     = '0;
                    row_next   = '0;
                    col_next   = '0;
                    sbest_next = best_reg;
                    state_next = ST_SC_RD;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                    if (col_reg == side_lm1)
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + RW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK:
            begin
                if (cell_q)
                begin
                    state_next = ST_SC_NEXT;
                end
                else
                begin
                    total_next = AREA_W'(1);
                    cnt_next   = '0;
                    dir_next   = DIR_UP;
                    state_next = ST_NB_SEL;
                end
            end
            ST_NB_SEL:
            begin
                if (dir_reg == DIR_DONE)
                begin
                    if (total_reg > sbest_reg)
                    begin
                        sbest_next = total_reg;
                    end
                    state_next = ST_SC_NEXT;
                end
                else if (nb_ok)
                begin
                    cell_raddr = nb_addr;
                    nb_next    = nb_addr;
                    state_next = ST_NB_CHK;
                end
                else
                begin
                    dir_next = dir_reg + 3'd1;
                end
            end
            ST_NB_CHK:
            begin
                if (cell_q)
                begin
                    x_next     = nb_reg;
                    role_next  = ROLE_SC;
                    state_next = ST_FIND_RD;
                end
                else
                begin
                    dir_next   = dir_reg + 3'd1;
                    state_next = ST_NB_SEL;
                end
            end
            ST_NB_AREA:
            begin
                total_next = total_reg + area_q;
                dir_next   = dir_reg + 3'd1;
                state_next = ST_NB_SEL;
            end
            ST_SC_NEXT:
            begin
                if (last_cell)
                begin
                    k_next     = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                    if (col_reg == side_lm1)
                    begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + RW'(1);
                    end
                    state_next = ST_SC_RD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (32'(sbest_reg) > 32'(OUT_MAX))
                    begin
                        out_data_next = OUT_MAX;
                    end
                    else
                    begin
                        out_data_next = OUT_W'(sbest_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            role_reg      <= ROLE_A;
            side_cfg_reg  <= CFG_W'(64);
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_bit_reg   <= 1'b0;
            prev_bit_reg  <= 1'b0;
            mleft_reg     <= 1'b0;
            best_reg      <= '0;
            sbest_reg     <= '0;
            total_reg     <= '0;
            area_a_reg    <= '0;
            x_reg         <= '0;
            nb_reg        <= '0;
            ra_reg        <= '0;
            dir_reg       <= DIR_UP;
            cnt_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                roots_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            role_reg      <= role_next;
            side_cfg_reg  <= side_cfg_next;
            k_reg         <= k_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_bit_reg   <= cur_bit_next;
            prev_bit_reg  <= prev_bit_next;
            mleft_reg     <= mleft_next;
            best_reg      <= best_next;
            sbest_reg     <= sbest_next;
            total_reg     <= total_next;
            area_a_reg    <= area_a_next;
            x_reg         <= x_next;
            nb_reg        <= nb_next;
            ra_reg        <= ra_next;
            dir_reg       <= dir_next;
            cnt_reg       <= cnt_next;
            roots_reg     <= roots_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    lio_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (k_reg),
        .wdata (s_tdata[0]),
        .raddr (cell_raddr),
        .rdata (cell_q)
    );

    lio_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (x_reg),
        .rdata (link_q)
    );

    lio_ram #(.WIDTH(AREA_W), .DEPTH(CELLS)) u_area_ram (
        .clk   (clk),
        .we    (area_we),
        .waddr (area_waddr),
        .wdata (area_wdata),
        .raddr (area_raddr),
        .rdata (area_q)
    );

endmodule

### bench/largest_island_after_one_flip_unit_checker.sv
module largest_island_after_one_flip_unit_checker
    import lio_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending_areas
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;

    logic [CFG_W-1:0] side_reg;
    bit               grid_bit [CELLS];
    int               parent [CELLS];
    int               area [CELLS];
    int               loaded;
    int               best_seen;
    logic [OUT_W-1:0] area_queue [$];

    assign pending_areas = area_queue.size();

    function automatic int root_of(int x);
        int r;
        int nxt;
        r = x;
        while (parent[r] != r)
            r = parent[r];
        while (parent[x] != r)
        begin
            nxt = parent[x];
            parent[x] = r;
            x = nxt;
        end
        return r;
    endfunction

    function automatic void join_cells(int a, int b);
        int ra;
        int rb;
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb)
            return;
        if (area[ra] < area[rb])
        begin
            parent[ra] = rb;
            area[rb] += area[ra];
        end
        else
        begin
            parent[rb] = ra;
            area[ra] += area[rb];
        end
    endfunction

    function automatic int flip_score(int n);
        int best;
        int roots [4];
        int cnt;
        int total;
        int nr;
        int nc;
        int idx;
        int rt;
        bit seen;
        best = best_seen;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                if (grid_bit[r*n+c])
                    continue;
                cnt = 0;
                total = 1;
                for (int d = 0; d < 4; d++)
                begin
                    nr = r + ((d == 0) ? -1 : (d == 3) ? 1 : 0);
                    nc = c + ((d == 1) ? -1 : (d == 2) ? 1 : 0);
                    if (nr < 0 || nr >= n || nc < 0 || nc >= n)
                        continue;
                    idx = nr*n + nc;
                    if (!grid_bit[idx])
                        continue;
                    rt = root_of(idx);
                    seen = 0;
                    for (int k = 0; k < cnt; k++)
                        if (roots[k] == rt)
                            seen = 1;
                    if (!seen)
                    begin
                        roots[cnt] = rt;
                        cnt++;
                        total += area[rt];
                    end
                end
                if (total > best)
                    best = total;
            end
        return best;
    endfunction

    function automatic void take_cell(bit b);
        int s;
        int k;
        int a;
        int res;
        s = (side_reg == 0) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
        if (loaded == 0)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                parent[i] = i;
                area[i] = 1;
            end
            best_seen = 0;
        end
        k = (loaded >= s*s) ? 0 : loaded;
        grid_bit[k] = b;
        if (b)
        begin
            if (k / s > 0 && grid_bit[k-s])
                join_cells(k, k - s);
            if (k % s > 0 && grid_bit[k-1])
                join_cells(k, k - 1);
            a = area[root_of(k)];
            if (a > best_seen)
                best_seen = a;
        end
        loaded = k + 1;
        if (loaded < s*s)
            return;
        res = flip_score(s);
        if (res > OUT_MAX)
            res = OUT_MAX;
        area_queue.push_back(res[OUT_W-1:0]);
        loaded = 0;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= 7'd64;
            loaded = 0;
            fail_count = 0;
            area_queue.delete();
        end
        else
        begin
            if (cfg_wen)
            begin
                side_reg <= cfg_data;
                loaded = 0;
            end
            else if (s_tvalid && s_tready)
                take_cell(s_tdata[0]);
            if (m_tvalid && m_tready)
            begin
                if (area_queue.size() == 0)
                    report("unexpected area", m_tdata, 0);
                else
                begin
                    if (m_tdata[OUT_W-1:0] != area_queue[0] || m_tdata[M_DATA_W-1:OUT_W] != 0)
                        report("largest_island", m_tdata, area_queue[0]);
                    void'(area_queue.pop_front());
                end
            end
        end
    end

endmodule

### bench/largest_island_after_one_flip_unit_tb.sv
module largest_island_after_one_flip_unit_tb;
    import lio_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [0] cell_value, rest stray bits
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [12:0] largest_island
    int                  fail_count;
    int                  pending_areas;
    int                  cycle_count = 0;
    bit                  hold_off;  // long receiver stall requested

    largest_island_after_one_flip_unit dut (.*);
    largest_island_after_one_flip_unit_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: the run ends as failed once the limit is passed, which only
    // a hang should reach.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 6000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall per item, plus one long hold-off.
    initial
    begin
        int gap;
        bit held;
        held = 0;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !held)
            begin
                held = 1;
                m_tready <= 0;
                repeat (3000) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    int  burst_mode;

    // tvalid stays high between items sent back to back
    task automatic send_cell(bit b);
        int gap;
        gap = (burst_mode != 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'($urandom_range(0, 127)), b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Wait until the block is idle before a register write.
    task automatic settle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_areas != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_side(int s);
        settle();
        cfg_wen  <= 1;
        cfg_data <= 7'(s);
        @(posedge clk);
        cfg_wen  <= 0;
    endtask

    // One grid; style picks fill: random density, all land, all water,
    // checkerboard, or stripes for long islands.
    task automatic send_grid(int s, int style);
        int dens;
        dens = $urandom_range(0, 100);
        for (int r = 0; r < s; r++)
            for (int c = 0; c < s; c++)
                case (style)
                    0: send_cell($urandom_range(0, 99) < dens);
                    1: send_cell(1'b1);
                    2: send_cell(1'b0);
                    3: send_cell(1'((r + c) % 2));
                    default: send_cell(c % 2 == 0 || r == s - 1);
                endcase
    endtask

    initial
    begin
        int sent;
        int s;
        int ngrids;
        bit stall_done;
        rst_n = 0;
        cfg_wen = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        hold_off = 0;
        burst_mode = 0;
        stall_done = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: side zero, side one, corner patterns.
        set_side(0);
        send_cell(1'b1);
        send_cell(1'b0);
        set_side(1);
        send_cell(1'b0);
        set_side(2);
        send_grid(2, 1);
        send_grid(2, 3);
        set_side(3);
        send_grid(3, 2);
        // Write in mid-grid drops the partial grid.
        send_cell(1'b1);
        send_cell(1'b1);
        set_side(2);
        send_grid(2, 0);

        // Random grids, mostly small sides; one long receiver hold-off
        // with back-to-back input so the block fills and stalls.
        sent = 0;
        while (sent < 920)
        begin
            s = $urandom_range(1, 7);
            if ($urandom_range(0, 9) == 0)
                s = $urandom_range(8, 12);
            ngrids = 3;
            if (sent > 300 && !stall_done)
            begin
                s = 3;
                ngrids = 6;
            end
            set_side(s);
            burst_mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
            if (ngrids == 6)
            begin
                stall_done = 1;
                hold_off = 1;
                burst_mode = 1;
            end
            for (int g = 0; g < ngrids; g++)
            begin
                send_grid(s, $urandom_range(0, 6) < 3 ? 0 : $urandom_range(1, 4));
                sent += s*s;
            end
        end
        burst_mode = 0;

        // Oversize write saturates to the largest side; the partial grid
        // is then dropped by the next write.
        set_side(127);
        for (int i = 0; i < 80; i++)
            send_cell(1'($urandom_range(0, 1)));
        set_side(3);
        send_grid(3, 1);

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
